@@ hdl/art_pkg.sv @@
// ----------------------------------------------------------------------------
// art_pkg
// Types and constants shared by the anchor range table.
// ----------------------------------------------------------------------------
package art_pkg;

    localparam int RANGE_BITS  = 20;
    localparam int ADDR_BITS   = 8;
    localparam int MODE_BITS   = 2;
    localparam int STATUS_BITS = 3;
    localparam int COUNT_BITS  = 5;

    // sum of three ranges, and the reciprocal used to divide it by three
    localparam int SUM_BITS  = RANGE_BITS + 2;
    localparam int DIV_SHIFT = SUM_BITS + 1;
    localparam int PROD_BITS = SUM_BITS + DIV_SHIFT;
    localparam logic [DIV_SHIFT-1:0] DIV3_MUL =
        DIV_SHIFT'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);

    // mode field codes
    localparam logic [MODE_BITS-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_UPDATE = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_DELETE = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_READ   = 2'd3;

    // status field codes
    localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_PRESENT   = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_ADDR_ZERO = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_UPDATE,
        OP_DELETE,
        OP_READ,
        OP_ZERO
    } t_op;

    typedef struct packed {
        logic [MODE_BITS-1:0]  mode;
        logic [ADDR_BITS-1:0]  anchor_address;
        logic [RANGE_BITS-1:0] new_range;
    } t_in;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [RANGE_BITS-1:0]  smoothed_range;
        logic [COUNT_BITS-1:0]  anchor_count;
    } t_out;

    typedef struct packed {
        t_op                   op;
        logic [ADDR_BITS-1:0]  addr;
        logic [RANGE_BITS-1:0] meas;
    } t_cmd;

    typedef struct packed {
        logic [RANGE_BITS-1:0] latest;
        logic [RANGE_BITS-1:0] previous;
        logic [RANGE_BITS-1:0] oldest;
    } t_hist;

endpackage

@@ hdl/anchor_range_table.sv @@
// ----------------------------------------------------------------------------
// anchor_range_table
// Table of ranging anchors with a three-deep smoothed range history.
// ----------------------------------------------------------------------------
// Use:
//   Requests enter on i_item (mode, anchor address, new range) and are
//   taken at a clock edge with push high and full low. Results leave on
//   o_result (status, smoothed range, anchor count) in request order; the
//   oldest one sits on the port while empty is low and is taken at an edge
//   with pop high.
//   Every request gives exactly one result.
// Timing:
//   An update adds a divide-by-three multiply stage to the engine's work;
//   address zero skips the lookup. Otherwise the time per request is set
//   by the lookup, which walks the address store one entry per cycle over
//   its single read port.
//   Two-entry queues sit before and after the engine, so the sender and
//   the receiver each stall on their own.
// Reset:
//   Synchronous, active low. All entries become free and the count zero;
//   both queues empty. No clearing pass is needed.
// Stall:
//   A full result queue holds the engine in its final state with the table
//   untouched; requests keep queueing until full rises.
// ----------------------------------------------------------------------------
module anchor_range_table #(
    parameter int MAX_ANCHORS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  art_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output art_pkg::t_out o_result
);

    localparam int QUEUE_DEPTH = 2;

    // front to command queue
    logic          front_push;
    art_pkg::t_cmd front_cmd;
    logic          cmd_full;

    // command queue to engine
    logic          cmd_empty;
    logic          cmd_pop;
    art_pkg::t_cmd cmd;

    // engine to result queue
    logic          res_push;
    logic          res_full;
    art_pkg::t_out res;

    // decode of mode and address zero
    art_front u_front (
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd_push (front_push),
        .o_cmd      (front_cmd),
        .i_cmd_full (cmd_full)
    );

    art_fifo #(
        .T     (art_pkg::t_cmd),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd),
        .o_empty (cmd_empty)
    );

    // lookup, history update and entry bookkeeping
    art_engine #(
        .MAX_ANCHORS (MAX_ANCHORS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // results wait here for the receiver
    art_fifo #(
        .T     (art_pkg::t_out),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

@@ hdl/art_fifo.sv @@
// ----------------------------------------------------------------------------
// art_fifo
// Small register FIFO, first-word fall-through.
// ----------------------------------------------------------------------------
module art_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            wr_en;
    logic            rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hdl/art_front.sv @@
// ----------------------------------------------------------------------------
// art_front
// Request decode: maps mode and address onto an engine command.
// ----------------------------------------------------------------------------
module art_front (
    input  logic          i_push,
    input  art_pkg::t_in  i_item,
    output logic          o_full,
    output logic          o_cmd_push,
    output art_pkg::t_cmd o_cmd,
    input  logic          i_cmd_full
);

    art_pkg::t_op op;

    always_comb begin
        case (i_item.mode)
            art_pkg::MODE_ADD:    op = art_pkg::OP_ADD;
            art_pkg::MODE_UPDATE: op = art_pkg::OP_UPDATE;
            art_pkg::MODE_DELETE: op = art_pkg::OP_DELETE;
            art_pkg::MODE_READ:   op = art_pkg::OP_READ;
            default:              op = art_pkg::OP_READ;
        endcase
        // address zero is refused whatever the mode
        if (i_item.anchor_address == '0) begin
            op = art_pkg::OP_ZERO;
        end
    end

    assign o_cmd.op   = op;
    assign o_cmd.addr = i_item.anchor_address;
    assign o_cmd.meas = i_item.new_range;
    assign o_cmd_push = i_push;
    assign o_full     = i_cmd_full;

endmodule

@@ hdl/art_engine.sv @@
// ----------------------------------------------------------------------------
// art_engine
// Table engine: scans the address store, then carries out one command.
// ----------------------------------------------------------------------------
module art_engine #(
    parameter int MAX_ANCHORS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_empty,
    input  art_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output art_pkg::t_out o_res
);

    localparam int IDX_W = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
    localparam int CNT_W = $clog2(MAX_ANCHORS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FETCH,
        S_EXEC,
        S_MUL,
        S_DONE
    } t_state;

    t_state                             r_state;
    art_pkg::t_cmd                      r_cmd;
    logic [MAX_ANCHORS-1:0]             r_valid;
    logic [CNT_W-1:0]                   r_total;
    logic [IDX_W-1:0]                   r_scan;
    logic [IDX_W-1:0]                   r_cmp_idx;
    logic                               r_cmp_live;
    logic                               r_hit;
    logic [IDX_W-1:0]                   r_slot;
    logic                               r_free_ok;
    logic [IDX_W-1:0]                   r_free;
    logic [art_pkg::SUM_BITS-1:0]       r_sum;
    logic [art_pkg::RANGE_BITS-1:0]     r_quot;

    logic [art_pkg::ADDR_BITS-1:0]      r_addr_mem [MAX_ANCHORS];
    art_pkg::t_hist                     r_hist_mem [MAX_ANCHORS];
    logic [art_pkg::ADDR_BITS-1:0]      r_addr_q;
    art_pkg::t_hist                     r_hist_q;

    logic                               do_done;
    logic                               wr_addr_en;
    logic                               wr_hist_en;
    logic [IDX_W-1:0]                   wr_idx;
    art_pkg::t_hist                     wr_hist;
    logic                               set_valid;
    logic                               clr_valid;
    logic [CNT_W-1:0]                   n_total;
    art_pkg::t_out                      res;
    logic [art_pkg::PROD_BITS-1:0]      prod;

    assign do_done   = (r_state == S_DONE) && !i_res_full;
    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty;
    assign o_res_push = do_done;
    assign o_res     = res;

    assign prod = art_pkg::PROD_BITS'(r_sum) * art_pkg::PROD_BITS'(art_pkg::DIV3_MUL);

    // address store: read at the scan pointer, written on add
    always_ff @(posedge i_clk) begin
        if (wr_addr_en) begin
            r_addr_mem[wr_idx] <= r_cmd.addr;
        end
        r_addr_q <= r_addr_mem[r_scan];
    end

    // range history store: read at the matched slot
    always_ff @(posedge i_clk) begin
        if (wr_hist_en) begin
            r_hist_mem[wr_idx] <= wr_hist;
        end
        r_hist_q <= r_hist_mem[r_slot];
    end

    always_comb begin
        wr_addr_en         = 1'b0;
        wr_hist_en         = 1'b0;
        wr_idx             = r_slot;
        wr_hist            = '0;
        set_valid          = 1'b0;
        clr_valid          = 1'b0;
        n_total            = r_total;
        res.status         = art_pkg::ST_OK;
        res.smoothed_range = '0;
        case (r_cmd.op)
            art_pkg::OP_ZERO: begin
                res.status = art_pkg::ST_ADDR_ZERO;
            end
            art_pkg::OP_ADD: begin
                if (r_hit) begin
                    res.status         = art_pkg::ST_PRESENT;
                    res.smoothed_range = r_hist_q.latest;
                end else if (!r_free_ok) begin
                    res.status = art_pkg::ST_FULL;
                end else begin
                    wr_idx     = r_free;
                    wr_addr_en = do_done;
                    wr_hist_en = do_done;
                    set_valid  = do_done;
                    n_total    = r_total + 1'b1;
                end
            end
            art_pkg::OP_UPDATE: begin
                if (!r_hit) begin
                    res.status = art_pkg::ST_NOT_FOUND;
                end else begin
                    wr_hist.latest     = r_quot;
                    wr_hist.previous   = r_hist_q.latest;
                    wr_hist.oldest     = r_hist_q.previous;
                    wr_hist_en         = do_done;
                    res.smoothed_range = r_quot;
                end
            end
            art_pkg::OP_DELETE: begin
                if (!r_hit) begin
                    res.status = art_pkg::ST_NOT_FOUND;
                end else begin
                    clr_valid = do_done;
                    if (r_total != '0) begin
                        n_total = r_total - 1'b1;
                    end
                end
            end
            art_pkg::OP_READ: begin
                if (!r_hit) begin
                    res.status = art_pkg::ST_NOT_FOUND;
                end else begin
                    res.smoothed_range = r_hist_q.latest;
                end
            end
            default: begin
                res.status = art_pkg::ST_ADDR_ZERO;
            end
        endcase
        res.anchor_count = art_pkg::COUNT_BITS'(n_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_total    <= '0;
            r_cmp_live <= 1'b0;
        end else begin
            // one entry compared per cycle, in the cycle after its read
            if (r_cmp_live) begin
                if (r_valid[r_cmp_idx] && (r_addr_q == r_cmd.addr) && !r_hit) begin
                    r_hit  <= 1'b1;
                    r_slot <= r_cmp_idx;
                end
                if (!r_valid[r_cmp_idx] && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                    r_free    <= r_cmp_idx;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd     <= i_cmd;
                        r_scan    <= '0;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_state   <= (i_cmd.op == art_pkg::OP_ZERO) ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cmp_idx  <= r_scan;
                    r_cmp_live <= 1'b1;
                    if (r_scan == IDX_W'(MAX_ANCHORS - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_cmp_live <= 1'b0;
                    r_state    <= S_FETCH;
                end
                S_FETCH: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_sum <= art_pkg::SUM_BITS'(r_cmd.meas)
                           + art_pkg::SUM_BITS'(r_hist_q.latest)
                           + art_pkg::SUM_BITS'(r_hist_q.previous);
                    r_state <= (r_cmd.op == art_pkg::OP_UPDATE && r_hit) ? S_MUL : S_DONE;
                end
                S_MUL: begin
                    r_quot  <= prod[art_pkg::DIV_SHIFT +: art_pkg::RANGE_BITS];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!i_res_full) begin
                        r_total <= n_total;
                        if (set_valid) begin
                            r_valid[r_free] <= 1'b1;
                        end
                        if (clr_valid) begin
                            r_valid[r_slot] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ verif/anchor_range_table_tb.sv @@
// ----------------------------------------------------------------------------
// anchor_range_table_tb
// Self-checking bench for the anchor range table.
// ----------------------------------------------------------------------------
// Requests go in through the push/full queue port. Each accepted request
// runs through a table model kept here, and the model's answer is queued
// as the expected result. A separate checker pops results with random
// stalls and compares every field against the oldest expected entry.
// Directed tests hit address zero, duplicate adds, smoothing extremes,
// a full table and misses. Random traffic mixes well-aimed operations
// with noise. A backpressure test holds the result side off long enough
// to stall the request side.
// ----------------------------------------------------------------------------
module anchor_range_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;
    localparam int POOL_SIZE   = 24;
    // idle window after the drain, sized from the worst engine latency and the two queues
    localparam int DRAIN_CYCLES = 2 * (TABLE_DEPTH + 6) + 8;
    localparam logic [art_pkg::RANGE_BITS-1:0] RANGE_MAX = '1;

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic          i_clk;
    logic          i_rst_n;
    logic          push;
    logic          full;
    art_pkg::t_in  i_item;
    logic          empty;
    logic          pop;
    art_pkg::t_out o_result;

    anchor_range_table #(
        .MAX_ANCHORS(TABLE_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    // ------------------------------------------------------------------
    // Table model state: a copy of what the block should hold
    // ------------------------------------------------------------------
    logic                           anchor_valid  [TABLE_DEPTH];
    logic [art_pkg::ADDR_BITS-1:0]  slot_addr     [TABLE_DEPTH];
    logic [art_pkg::RANGE_BITS-1:0] hist_latest   [TABLE_DEPTH];
    logic [art_pkg::RANGE_BITS-1:0] hist_previous [TABLE_DEPTH];
    logic [art_pkg::RANGE_BITS-1:0] hist_oldest   [TABLE_DEPTH];
    logic [art_pkg::COUNT_BITS-1:0] anchor_total;

    // results still owed by the block, oldest first
    art_pkg::t_out pending_results[$];

    // working set of addresses for random traffic
    logic [art_pkg::ADDR_BITS-1:0] addr_pool[POOL_SIZE];

    // idling controls, shared between the tests and the two sides
    bit          tx_idle_en;
    bit          rx_idle_en;
    int unsigned rx_hold_cycles;

    // bookkeeping
    int unsigned mismatch_count;
    int unsigned requests_sent;
    int unsigned results_checked;
    int unsigned full_stall_cycles;
    int unsigned status_seen[int'(art_pkg::ST_ADDR_ZERO) + 1];

    // ------------------------------------------------------------------
    // Clock, reset and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // generous: ~1550 requests at worst-case latency and stalls fit
    // many times over in this window
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------
    function automatic void clear_table_model();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            anchor_valid[i] = 1'b0;
            slot_addr[i] = '0;
            hist_latest[i] = '0;
            hist_previous[i] = '0;
            hist_oldest[i] = '0;
        end
        anchor_total = '0;
    endfunction

    // Applies one request to the model, returns the answer the block owes.
    function automatic art_pkg::t_out apply_anchor_request(input art_pkg::t_in req);
        art_pkg::t_out res;
        int hit;
        int free_idx;
        logic [art_pkg::SUM_BITS-1:0] sum;
        res = '0;
        res.status = art_pkg::ST_OK;
        hit = -1;
        free_idx = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (anchor_valid[i] && slot_addr[i] == req.anchor_address && hit < 0)
                hit = i;
            if (!anchor_valid[i] && free_idx < 0)
                free_idx = i;
        end
        if (req.anchor_address == '0) begin
            res.status = art_pkg::ST_ADDR_ZERO;
        end else if (req.mode == art_pkg::MODE_ADD) begin
            if (hit >= 0) begin
                res.status = art_pkg::ST_PRESENT;
                res.smoothed_range = hist_latest[hit];
            end else if (free_idx < 0) begin
                res.status = art_pkg::ST_FULL;
            end else begin
                // new entry lands in the lowest free slot, history zeroed
                anchor_valid[free_idx] = 1'b1;
                slot_addr[free_idx] = req.anchor_address;
                hist_latest[free_idx] = '0;
                hist_previous[free_idx] = '0;
                hist_oldest[free_idx] = '0;
                anchor_total = anchor_total + 1'b1;
            end
        end else if (hit < 0) begin
            res.status = art_pkg::ST_NOT_FOUND;
        end else if (req.mode == art_pkg::MODE_UPDATE) begin
            // shift history, then truncated mean of new range and two prior
            hist_oldest[hit] = hist_previous[hit];
            hist_previous[hit] = hist_latest[hit];
            sum = art_pkg::SUM_BITS'(req.new_range)
                + art_pkg::SUM_BITS'(hist_previous[hit])
                + art_pkg::SUM_BITS'(hist_oldest[hit]);
            hist_latest[hit] = art_pkg::RANGE_BITS'(sum / 3);
            res.smoothed_range = hist_latest[hit];
        end else if (req.mode == art_pkg::MODE_DELETE) begin
            anchor_valid[hit] = 1'b0;
            if (anchor_total != '0)
                anchor_total = anchor_total - 1'b1;
        end else begin
            res.smoothed_range = hist_latest[hit];
        end
        res.anchor_count = anchor_total;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic art_pkg::t_in make_request(
        input logic [art_pkg::MODE_BITS-1:0]  mode,
        input logic [art_pkg::ADDR_BITS-1:0]  addr,
        input logic [art_pkg::RANGE_BITS-1:0] meas);
        art_pkg::t_in req;
        req.mode = mode;
        req.anchor_address = addr;
        req.new_range = meas;
        return req;
    endfunction

    // Called at a rising edge; returns at the edge that takes the request.
    task automatic send_request(input art_pkg::t_in req);
        int unsigned gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= req;
        @(posedge i_clk);
        while (full) begin
            full_stall_cycles++;
            @(posedge i_clk);
        end
        pending_results.push_back(apply_anchor_request(req));
        requests_sent++;
    endtask

    // Sender goes quiet until every owed result has come back.
    task automatic wait_for_drain();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic void refresh_addr_pool();
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = art_pkg::ADDR_BITS'($urandom_range(1, 255));
    endfunction

    // Mostly aimed at addresses the table holds or the working set, with
    // a sprinkle of address zero and stray addresses.
    function automatic art_pkg::t_in random_request();
        art_pkg::t_in req;
        int unsigned r;
        int unsigned m;
        int start;
        m = $urandom_range(0, 99);
        if (m < 25)
            req.mode = art_pkg::MODE_ADD;
        else if (m < 60)
            req.mode = art_pkg::MODE_UPDATE;
        else if (m < 75)
            req.mode = art_pkg::MODE_DELETE;
        else
            req.mode = art_pkg::MODE_READ;

        r = $urandom_range(0, 99);
        req.anchor_address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 5) begin
            req.anchor_address = '0;
        end else if (req.mode != art_pkg::MODE_ADD && r < 55 && anchor_total != '0) begin
            // pick a held entry, scanning from a random slot
            start = $urandom_range(0, TABLE_DEPTH - 1);
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (anchor_valid[(start + i) % TABLE_DEPTH]) begin
                    req.anchor_address = slot_addr[(start + i) % TABLE_DEPTH];
                    break;
                end
            end
        end else if (r >= 90 && req.mode != art_pkg::MODE_ADD) begin
            req.anchor_address = art_pkg::ADDR_BITS'($urandom_range(1, 255));
        end

        r = $urandom_range(0, 99);
        if (r < 8)
            req.new_range = '0;
        else if (r < 16)
            req.new_range = RANGE_MAX;
        else
            req.new_range = art_pkg::RANGE_BITS'($urandom);
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Result side: pops with random stalls, checks against the model
    // ------------------------------------------------------------------
    task automatic check_result(input art_pkg::t_out got);
        art_pkg::t_out want;
        if (pending_results.size() == 0) begin
            $display("%0t: result with nothing pending: actual %p", $time, got);
            mismatch_count++;
        end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (got.status <= art_pkg::ST_ADDR_ZERO)
                status_seen[got.status]++;
            if (got.status !== want.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, got.status);
                mismatch_count++;
            end
            if (got.smoothed_range !== want.smoothed_range) begin
                $display("%0t: smoothed_range mismatch: expected %0d actual %0d",
                         $time, want.smoothed_range, got.smoothed_range);
                mismatch_count++;
            end
            if (got.anchor_count !== want.anchor_count) begin
                $display("%0t: anchor_count mismatch: expected %0d actual %0d",
                         $time, want.anchor_count, got.anchor_count);
                mismatch_count++;
            end
        end
    endtask

    initial begin : result_checker
        int unsigned rx_gap;
        rx_gap = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            // values seen here are from before this edge's updates
            if (pop && !empty)
                check_result(o_result);
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (rx_hold_cycles > 0) begin
                // long hold-off requested by the backpressure test
                pop <= 1'b0;
                rx_hold_cycles--;
            end else if (rx_gap > 0) begin
                pop <= 1'b0;
                rx_gap--;
            end else begin
                pop <= 1'b1;
                if (rx_idle_en)
                    rx_gap = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Address zero is refused in every mode, table untouched.
    task automatic test_address_zero();
        send_request(make_request(art_pkg::MODE_ADD, '0, RANGE_MAX));
        send_request(make_request(art_pkg::MODE_UPDATE, '0, RANGE_MAX));
        send_request(make_request(art_pkg::MODE_DELETE, '0, '0));
        send_request(make_request(art_pkg::MODE_READ, '0, 20'h5_5555));
        wait_for_drain();
    endtask

    // Add, duplicate add, smoothing at the range extremes and a read.
    task automatic test_smoothing();
        send_request(make_request(art_pkg::MODE_ADD, 8'hFF, 20'hA_AAAA));
        send_request(make_request(art_pkg::MODE_ADD, 8'hFF, '0));
        send_request(make_request(art_pkg::MODE_UPDATE, 8'hFF, RANGE_MAX));
        send_request(make_request(art_pkg::MODE_UPDATE, 8'hFF, RANGE_MAX));
        send_request(make_request(art_pkg::MODE_UPDATE, 8'hFF, '0));
        send_request(make_request(art_pkg::MODE_READ, 8'hFF, RANGE_MAX));
        wait_for_drain();
    endtask

    // Fill every slot, overflow it, then misses after a delete.
    task automatic test_table_capacity();
        for (int i = 1; i < TABLE_DEPTH; i++)
            send_request(make_request(art_pkg::MODE_ADD,
                                      art_pkg::ADDR_BITS'(i * 17 - (i % 2) * 16),
                                      art_pkg::RANGE_BITS'(i)));
        send_request(make_request(art_pkg::MODE_ADD, 8'h7E, '0));      // table full
        send_request(make_request(art_pkg::MODE_DELETE, 8'hFF, '0));
        send_request(make_request(art_pkg::MODE_READ, 8'hFF, '0));     // not found
        send_request(make_request(art_pkg::MODE_UPDATE, 8'hFF, RANGE_MAX));
        send_request(make_request(art_pkg::MODE_DELETE, 8'hFF, '0));
        wait_for_drain();
    endtask

    // Result side holds off long enough for the block to stall its input.
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_hold_cycles = 400;
        for (int i = 0; i < 24; i++)
            send_request(random_request());
        wait_for_drain();
    endtask

    // No idling on either side.
    task automatic test_back_to_back(input int unsigned count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int unsigned i = 0; i < count; i++)
            send_request(random_request());
        wait_for_drain();
    endtask

    // Random traffic with gaps on both sides; working set shifts now and then.
    task automatic test_random_mix(input int unsigned count);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 200 == 0)
                refresh_addr_pool();
            send_request(random_request());
        end
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_item <= '0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        rx_hold_cycles = 0;
        mismatch_count = 0;
        requests_sent = 0;
        results_checked = 0;
        full_stall_cycles = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        clear_table_model();
        refresh_addr_pool();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_address_zero();
        test_smoothing();
        test_table_capacity();
        test_random_mix(300);
        test_backpressure();
        test_back_to_back(200);
        rx_idle_en = 1'b1;
        test_random_mix(1000);

        // everything owed has arrived; watch for stray extra results
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests and %0d checked results, %0d input stall cycles.",
                 requests_sent, results_checked, full_stall_cycles);
        $display("Statuses: ok %0d, not found %0d, present %0d, full %0d, address zero %0d.",
                 status_seen[art_pkg::ST_OK], status_seen[art_pkg::ST_NOT_FOUND],
                 status_seen[art_pkg::ST_PRESENT], status_seen[art_pkg::ST_FULL],
                 status_seen[art_pkg::ST_ADDR_ZERO]);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
